/* hdl/tss_pkg.sv */
// Shared types for the two-stacks-in-one-memory block: command and result
// beats, operation and status codes, and the control-to-top response bundle.
// No dependencies.
package tss_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_MODIFY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic               stack_sel;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    status_t            status;
    logic [7:0]         count_up;
    logic [7:0]         count_down;
  } out_item_t;

  // Registered outcome of one command, aligned with the memory read data.
  typedef struct packed {
    logic       valid;
    logic       rd_sel;
    status_t    status;
    logic [7:0] count_up;
    logic [7:0] count_down;
  } rsp_t;

endpackage

/* hdl/tss_mem.sv */
// Single-port synchronous word store shared by both stacks.
// Registered read: data appears in the cycle after the address. Depends on nothing.
module tss_mem #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/tss_ctrl.sv */
// Stack pointer control: decodes a command beat, checks bounds, drives the
// store address and write, and registers the outcome. Depends on tss_pkg.
module tss_ctrl #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  tss_pkg::in_item_t     item,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_addr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output tss_pkg::rsp_t         rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  logic [CW-1:0]     up_cnt, up_cnt_next;
  logic [CW-1:0]     down_base, down_base_next;
  logic [CW-1:0]     down_cnt, down_cnt_next;
  logic [CW-1:0]     sel_cnt;
  logic [PW-1:0]     pos_w, idx_w;
  logic              full;
  logic              rd_sel_next;
  tss_pkg::status_t  status_next;

  assign down_cnt      = CW'(DEPTH) - down_base;
  assign down_cnt_next = CW'(DEPTH) - down_base_next;
  assign sel_cnt       = item.stack_sel ? down_cnt : up_cnt;
  assign full          = (up_cnt == down_base);
  assign pos_w         = PW'(item.position);
  assign idx_w         = item.stack_sel ? (PW'(down_base) + pos_w - PW'(1))
                                        : (PW'(up_cnt) - pos_w);
  assign mem_wdata     = DATA_WIDTH'($unsigned(item.value));

  always_comb begin
    up_cnt_next    = up_cnt;
    down_base_next = down_base;
    mem_we         = 1'b0;
    mem_addr       = idx_w[AW-1:0];
    rd_sel_next    = 1'b0;
    status_next    = tss_pkg::ST_OK;
    case (item.mode)
      tss_pkg::MODE_PUSH: begin
        if (full) begin
          status_next = tss_pkg::ST_OVERFLOW;
        end else if (item.stack_sel) begin
          down_base_next = down_base - CW'(1);
          mem_addr       = down_base_next[AW-1:0];
          mem_we         = accept;
        end else begin
          up_cnt_next = up_cnt + CW'(1);
          mem_addr    = up_cnt[AW-1:0];
          mem_we      = accept;
        end
      end
      tss_pkg::MODE_POP: begin
        if (sel_cnt == '0) begin
          status_next = tss_pkg::ST_UNDERFLOW;
        end else if (item.stack_sel) begin
          down_base_next = down_base + CW'(1);
          mem_addr       = down_base[AW-1:0];
          rd_sel_next    = 1'b1;
        end else begin
          up_cnt_next = up_cnt - CW'(1);
          mem_addr    = up_cnt_next[AW-1:0];
          rd_sel_next = 1'b1;
        end
      end
      tss_pkg::MODE_PEEK, tss_pkg::MODE_MODIFY: begin
        if (pos_w == '0 || pos_w > PW'(sel_cnt)) begin
          status_next = tss_pkg::ST_BADPOS;
        end else if (item.mode == tss_pkg::MODE_PEEK) begin
          rd_sel_next = 1'b1;
        end else begin
          mem_we = accept;
        end
      end
      default: begin
        status_next = tss_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_cnt    <= '0;
      down_base <= CW'(DEPTH);
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= accept;
      if (accept) begin
        up_cnt    <= up_cnt_next;
        down_base <= down_base_next;
      end
    end
    if (accept) begin
      rsp.rd_sel     <= rd_sel_next;
      rsp.status     <= status_next;
      rsp.count_up   <= 8'(up_cnt_next);
      rsp.count_down <= 8'(down_cnt_next);
    end
  end

endmodule

/* hdl/two_stacks_shared_memory_top.sv */
// Two stacks sharing one word store: the upward stack grows from index 0 and
// the downward stack from index DEPTH-1. A command is taken every cycle that
// start is high and busy is low; busy is high only during reset and the
// cycle after it. Each command gives exactly one result, on the ports for one
// cycle with done high, in the cycle right after the command was taken, as the
// read of the single-port store is registered; since each command touches one
// word and one pointer, one command per cycle is sustained. The receiver cannot
// stall and must take every result beat.
// Store contents are undefined after reset; no clearing pass is needed.
// Depends on tss_pkg, tss_ctrl, tss_mem.
module two_stacks_shared_memory_top #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tss_pkg::in_item_t  item,
  output logic               done,
  output tss_pkg::out_item_t result
);

  localparam int AW = $clog2(DEPTH);

  logic                  accept;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;
  tss_pkg::rsp_t         rsp;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  tss_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .rsp       (rsp)
  );

  tss_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Read data lines up with the registered outcome in the cycle after accept.
  assign done              = rsp.valid;
  assign result.read_data  = rsp.rd_sel ? $signed(32'(mem_rdata)) : '0;
  assign result.status     = rsp.status;
  assign result.count_up   = rsp.count_up;
  assign result.count_down = rsp.count_down;

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted beat produced no result");

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result without an accepted beat");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != tss_pkg::ST_OK) |-> (result.read_data == '0))
    else $error("nonzero read data on a failed command");

  a_no_write_on_error: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> accept)
    else $error("store written without an accepted beat");

endmodule

/* tb/tss_result_checker.sv */
// Result checker for two_stacks_shared_memory_top: watches command and result beats,
// predicts each result from a shadow copy of both stacks, and compares field by field.
// Depends on tss_pkg.
module tss_result_checker #(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  tss_pkg::in_item_t  item,
  input  logic               done,
  input  tss_pkg::out_item_t result,
  output int                 fail_count,
  output int                 outstanding,
  output int                 up_level,
  output int                 down_level
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0]  word_store [DEPTH];
  int                  up_count   = 0;
  int                  down_base  = DEPTH;
  tss_pkg::out_item_t  awaited_results[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    up_level    = 0;
    down_level  = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Applies one command to the shadow stacks and returns the result it should give.
  function automatic tss_pkg::out_item_t apply_stack_op(input tss_pkg::in_item_t c);
    tss_pkg::out_item_t r;
    int                 used;
    int                 slot;
    r        = '0;
    r.status = tss_pkg::ST_OK;
    used     = c.stack_sel ? DEPTH - down_base : up_count;
    case (c.mode)
      tss_pkg::MODE_PUSH: begin
        if (up_count < down_base) begin
          if (c.stack_sel) begin
            down_base--;
            word_store[down_base] = c.value;
          end else begin
            word_store[up_count] = c.value;
            up_count++;
          end
        end else begin
          r.status = tss_pkg::ST_OVERFLOW;
        end
      end
      tss_pkg::MODE_POP: begin
        if (used == 0) begin
          r.status = tss_pkg::ST_UNDERFLOW;
        end else if (c.stack_sel) begin
          r.read_data = word_store[down_base];
          down_base++;
        end else begin
          up_count--;
          r.read_data = word_store[up_count];
        end
      end
      default: begin
        if (c.position == 0 || int'(c.position) > used) begin
          r.status = tss_pkg::ST_BADPOS;
        end else begin
          slot = c.stack_sel ? down_base + int'(c.position) - 1 : up_count - int'(c.position);
          if (c.mode == tss_pkg::MODE_PEEK) r.read_data = word_store[slot];
          else word_store[slot] = c.value;
        end
      end
    endcase
    r.count_up   = 8'(up_count);
    r.count_down = 8'(DEPTH - down_base);
    return r;
  endfunction

  always @(posedge clk) begin
    tss_pkg::out_item_t want;
    if (!rst && $isunknown(done)) report_mismatch("done unknown", 32'(done), 32'd0);
    if (done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 32'(result), 32'd0);
      end else begin
        want = awaited_results.pop_front();
        if (result.read_data !== want.read_data)
          report_mismatch("read_data", result.read_data, want.read_data);
        if (result.status !== want.status)
          report_mismatch("status", 32'(result.status), 32'(want.status));
        if (result.count_up !== want.count_up)
          report_mismatch("count_up", 32'(result.count_up), 32'(want.count_up));
        if (result.count_down !== want.count_down)
          report_mismatch("count_down", 32'(result.count_down), 32'(want.count_down));
      end
    end
    if (!rst && start === 1'b1 && busy === 1'b0)
      awaited_results.push_back(apply_stack_op(item));
    outstanding <= awaited_results.size();
    up_level    <= up_count;
    down_level  <= DEPTH - down_base;
  end

endmodule

/* tb/testbench.sv */
// Top of the two-stacks bench: clock, reset, command stimulus and the verdict.
// Depends on tss_pkg, tss_result_checker and the RTL top two_stacks_shared_memory_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 128;
  localparam int RANDOM_BEATS = 1800;
  localparam int CYCLE_LIMIT  = 100000;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               done;
  tss_pkg::in_item_t  item  = '0;
  tss_pkg::out_item_t result;

  int fail_count;
  int outstanding;
  int up_level;
  int down_level;
  int cycles     = 0;
  int beats_sent = 0;
  bit no_idle    = 1'b0;

  two_stacks_shared_memory_top #(.DEPTH(DEPTH), .DATA_WIDTH(32)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  tss_result_checker #(.DEPTH(DEPTH)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .up_level    (up_level),
    .down_level  (down_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic tss_pkg::in_item_t make_beat(input tss_pkg::mode_t m, input logic sel,
                                                  input logic [7:0] pos,
                                                  input logic [31:0] v);
    tss_pkg::in_item_t c;
    c.mode      = m;
    c.stack_sel = sel;
    c.position  = pos;
    c.value     = v;
    return c;
  endfunction

  // Holds the beat on the bus until the block takes it.
  task automatic send_beat(input tss_pkg::in_item_t c);
    start <= 1'b1;
    item  <= c;
    do @(posedge clk); while (busy !== 1'b0);
    beats_sent++;
    if (!no_idle && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      item  <= make_beat(tss_pkg::mode_t'($urandom_range(0, 3)), 1'($urandom),
                         8'($urandom), $urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_drained;
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Random command with the given push and pop percentages; rest is peek/modify.
  task automatic send_random_beat(input int push_pct, input int pop_pct);
    tss_pkg::in_item_t c;
    int                lvl;
    int                roll;
    c.stack_sel = 1'($urandom);
    c.value     = $urandom;
    c.position  = 8'($urandom);
    lvl         = c.stack_sel ? down_level : up_level;
    roll        = $urandom_range(0, 99);
    if (roll < push_pct) c.mode = tss_pkg::MODE_PUSH;
    else if (roll < push_pct + pop_pct) c.mode = tss_pkg::MODE_POP;
    else c.mode = $urandom_range(0, 1) ? tss_pkg::MODE_PEEK : tss_pkg::MODE_MODIFY;
    if (c.mode == tss_pkg::MODE_PEEK || c.mode == tss_pkg::MODE_MODIFY) begin
      roll = $urandom_range(0, 99);
      // levels lag by a beat, so "valid" picks are mostly but not always valid
      if (roll < 72 && lvl > 0) c.position = 8'($urandom_range(1, lvl));
      else if (roll < 80) c.position = 8'(lvl);
      else if (roll < 86) c.position = 8'd0;
      else if (roll < 93) c.position = 8'(lvl + 1);
      else c.position = 8'($urandom_range(0, 255));
    end
    send_beat(c);
  endtask

  initial begin
    int phase;
    int span;
    int push_pct;
    int pop_pct;
    int goal;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty stacks
    send_beat(make_beat(tss_pkg::MODE_POP,    1'b0, 8'd0,   32'h1111_1111));
    send_beat(make_beat(tss_pkg::MODE_POP,    1'b1, 8'd1,   32'h2222_2222));
    send_beat(make_beat(tss_pkg::MODE_PEEK,   1'b0, 8'd1,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_MODIFY, 1'b1, 8'd0,   32'hdead_beef));
    // extreme data words
    send_beat(make_beat(tss_pkg::MODE_PUSH,   1'b0, 8'd0,   32'h7fff_ffff));
    send_beat(make_beat(tss_pkg::MODE_PUSH,   1'b0, 8'd255, 32'h8000_0000));
    send_beat(make_beat(tss_pkg::MODE_PUSH,   1'b0, 8'd0,   32'h0000_0000));
    send_beat(make_beat(tss_pkg::MODE_PUSH,   1'b1, 8'd128, 32'hffff_ffff));
    send_beat(make_beat(tss_pkg::MODE_PUSH,   1'b1, 8'd0,   32'h1234_5678));
    // positions: top, bottom, one past, zero, far out
    send_beat(make_beat(tss_pkg::MODE_PEEK,   1'b0, 8'd1,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_PEEK,   1'b0, 8'd3,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_PEEK,   1'b0, 8'd4,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_PEEK,   1'b0, 8'd0,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_PEEK,   1'b1, 8'd2,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_PEEK,   1'b1, 8'd255, 32'h0));
    send_beat(make_beat(tss_pkg::MODE_MODIFY, 1'b0, 8'd3,   32'ha5a5_a5a5));
    send_beat(make_beat(tss_pkg::MODE_MODIFY, 1'b1, 8'd1,   32'h5a5a_5a5a));
    send_beat(make_beat(tss_pkg::MODE_MODIFY, 1'b1, 8'd3,   32'hffff_0000));
    send_beat(make_beat(tss_pkg::MODE_PEEK,   1'b0, 8'd3,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_POP,    1'b1, 8'd0,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_POP,    1'b1, 8'd0,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_POP,    1'b1, 8'd0,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_POP,    1'b0, 8'd0,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_POP,    1'b0, 8'd0,   32'h0));
    send_beat(make_beat(tss_pkg::MODE_POP,    1'b0, 8'd0,   32'h0));
    wait_drained();

    // Fill, drain, then random fill/drain/mixed; fills run long enough to fill memory.
    goal  = beats_sent + RANDOM_BEATS;
    phase = 0;
    while (beats_sent < goal) begin
      case (phase == 0 ? 0 : phase == 1 ? 1 : $urandom_range(0, 2))
        0: begin
          push_pct = 85; pop_pct = 5;  span = $urandom_range(220, 300);
        end
        1: begin
          push_pct = 10; pop_pct = 65; span = $urandom_range(150, 250);
        end
        default: begin
          push_pct = 40; pop_pct = 30; span = $urandom_range(100, 200);
        end
      endcase
      no_idle = (phase == 2);
      repeat (span) begin
        if (beats_sent < goal) send_random_beat(push_pct, pop_pct);
      end
      no_idle = 1'b0;
      if (phase % 2 == 1) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
